// ===== sv/gbfs_pkg.sv =====
// Shared types, sizes and codes for the graph BFS engine.
// No dependencies; imported by graph_bfs_engine and gbfs_core.
`default_nettype none

package gbfs_pkg;

    localparam int MAX_VERTICES = 64;
    localparam int MAX_ENTRIES  = 256;

    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;
    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 2;

    localparam int V_AW    = $clog2(MAX_VERTICES);
    localparam int E_AW    = $clog2(MAX_ENTRIES);
    localparam int LINK_W  = E_AW + 1;
    localparam int QP_W    = V_AW + 1;
    localparam int ENTRY_W = LINK_W + VERTEX_W;
    localparam int VLIST_W = 2 * E_AW;

    localparam logic [LINK_W-1:0]  EMPTY_LINK   = LINK_W'(MAX_ENTRIES);
    localparam logic [LINK_W-1:0]  FULL_LEVEL   = LINK_W'(MAX_ENTRIES - 2);
    localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;
    localparam logic [COUNT_W-1:0] VCOUNT_MAX   = COUNT_W'(MAX_VERTICES);

    typedef enum logic [OPCODE_W-1:0] {
        OP_ADD_EDGE = 2'd0,
        OP_TRAVERSE = 2'd1,
        OP_CLEAR    = 2'd2,
        OP_NONE     = 2'd3
    } gbfs_op_t;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex_b;
        logic [VERTEX_W-1:0] vertex_a;
        logic [OPCODE_W-1:0] opcode;
    } gbfs_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                last;
        logic [VERTEX_W-1:0] vertex;
    } gbfs_result_t;

endpackage

`default_nettype wire

// ===== sv/graph_bfs_engine.sv =====
// Graph BFS engine top level: stream ports, vertex_count register and
// output register stage around gbfs_core. Depends on gbfs_pkg, gbfs_core.
//
// Undirected graph held as per-vertex adjacency lists in on-chip RAM, with
// breadth-first traversal. Input tdata: opcode (0 add edge, 1 traverse,
// 2 clear, 3 ignored), vertex_a, vertex_b. Each add or clear returns one
// status transfer; a traverse returns the reachable vertices in BFS order
// with tlast on the final one. One item is worked at a time. An add edge
// makes two read-modify-write appends to the list and entry RAMs. A
// traverse walks the adjacency chains through the entry RAM read port,
// which follows one link per cycle. Results leave through a register, so
// the next item is taken while the last result waits.
`default_nettype none

module graph_bfs_engine (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [15:0]                   s_tdata,  // opcode, vertex_a, vertex_b, pad
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,  // vertex, pad
    output logic                               m_tlast,
    output logic [gbfs_pkg::STATUS_W-1:0]      m_tuser,  // status
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [gbfs_pkg::COUNT_W-1:0]  cfg_data
);
    import gbfs_pkg::*;

    logic [COUNT_W-1:0] vcount_reg;
    logic [COUNT_W-1:0] vlimit;
    gbfs_item_t         item;
    logic               res_valid, res_ready;
    gbfs_result_t       res;
    logic               out_valid_reg;
    gbfs_result_t       out_reg;

    assign cfg_ready = 1'b1;
    assign vlimit    = (vcount_reg > VCOUNT_MAX) ? VCOUNT_MAX : vcount_reg;
    assign item      = s_tdata[$bits(gbfs_item_t)-1:0];
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vcount_reg <= VCOUNT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            vcount_reg <= cfg_data;
        end
    end

    gbfs_core u_core (
        .aclk(aclk),
        .aresetn(aresetn),
        .in_valid(s_tvalid),
        .in_ready(s_tready),
        .in_item(item),
        .vlimit(vlimit),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_valid && res_ready) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (res_valid && res_ready) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8 - VERTEX_W){1'b0}}, out_reg.vertex};
    assign m_tlast  = out_reg.last;
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire

// ===== sv/gbfs_ram.sv =====
// Generic simple dual-port synchronous RAM with registered read.
// No dependencies.
`default_nettype none

module gbfs_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/gbfs_core.sv =====
// Graph store and BFS sequencer: adjacency lists, entry chain and BFS queue
// held in gbfs_ram instances. Depends on gbfs_pkg and gbfs_ram.
`default_nettype none

module gbfs_core (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire gbfs_pkg::gbfs_item_t           in_item,
    input  wire logic [gbfs_pkg::COUNT_W-1:0]   vlimit,
    output logic                                res_valid,
    input  wire logic                           res_ready,
    output gbfs_pkg::gbfs_result_t              res
);
    import gbfs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD_RD,
        S_ADD_WR,
        S_ADD_LINK,
        S_ADD_STEP,
        S_TRV_INIT,
        S_TRV_POP,
        S_TRV_HEAD,
        S_TRV_LIST,
        S_TRV_ENT,
        S_EMIT
    } state_t;

    state_t                  state_reg, state_next;
    logic [VERTEX_W-1:0]     owner_reg, owner_next;
    logic [VERTEX_W-1:0]     nbr_reg, nbr_next;
    logic                    second_reg, second_next;
    logic [E_AW-1:0]         tail_reg, tail_next;
    logic [E_AW-1:0]         new_e_reg, new_e_next;
    logic [LINK_W-1:0]       used_reg, used_next;
    logic [VERTEX_W-1:0]     cur_reg, cur_next;
    logic [QP_W-1:0]         rp_reg, rp_next;
    logic [QP_W-1:0]         wp_reg, wp_next;
    logic [MAX_VERTICES-1:0] hv_reg, hv_next;
    logic [MAX_VERTICES-1:0] disc_reg, disc_next;
    gbfs_result_t            res_reg, res_next;

    logic               vl_we, vl_re;
    logic [V_AW-1:0]    vl_waddr, vl_raddr;
    logic [VLIST_W-1:0] vl_wdata, vl_rdata;
    logic               en_we, en_re;
    logic [E_AW-1:0]    en_waddr, en_raddr;
    logic [ENTRY_W-1:0] en_wdata, en_rdata;
    logic               q_we, q_re;
    logic [V_AW-1:0]    q_waddr, q_raddr;
    logic [VERTEX_W-1:0] q_wdata, q_rdata;

    logic [E_AW-1:0]     vl_head, vl_tail;
    logic [VERTEX_W-1:0] en_nb;
    logic [LINK_W-1:0]   en_link;
    logic                had_list, enq, a_bad, b_bad;

    assign vl_head = vl_rdata[E_AW-1:0];
    assign vl_tail = vl_rdata[VLIST_W-1:E_AW];
    assign en_nb   = en_rdata[VERTEX_W-1:0];
    assign en_link = en_rdata[ENTRY_W-1:VERTEX_W];
    assign a_bad   = {1'b0, in_item.vertex_a} >= vlimit;
    assign b_bad   = {1'b0, in_item.vertex_b} >= vlimit;

    gbfs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VLIST_W)) u_vlist (
        .aclk(aclk), .wr_en(vl_we), .wr_addr(vl_waddr), .wr_data(vl_wdata),
        .rd_en(vl_re), .rd_addr(vl_raddr), .rd_data(vl_rdata)
    );

    gbfs_ram #(.DEPTH(MAX_ENTRIES), .WIDTH(ENTRY_W)) u_entry (
        .aclk(aclk), .wr_en(en_we), .wr_addr(en_waddr), .wr_data(en_wdata),
        .rd_en(en_re), .rd_addr(en_raddr), .rd_data(en_rdata)
    );

    gbfs_ram #(.DEPTH(MAX_VERTICES), .WIDTH(VERTEX_W)) u_queue (
        .aclk(aclk), .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata),
        .rd_en(q_re), .rd_addr(q_raddr), .rd_data(q_rdata)
    );

    always_comb begin
        state_next  = state_reg;
        owner_next  = owner_reg;
        nbr_next    = nbr_reg;
        second_next = second_reg;
        tail_next   = tail_reg;
        new_e_next  = new_e_reg;
        used_next   = used_reg;
        cur_next    = cur_reg;
        rp_next     = rp_reg;
        wp_next     = wp_reg;
        hv_next     = hv_reg;
        disc_next   = disc_reg;
        res_next    = res_reg;

        vl_we    = 1'b0;
        vl_waddr = owner_reg[V_AW-1:0];
        vl_wdata = {used_reg[E_AW-1:0], used_reg[E_AW-1:0]};
        vl_re    = 1'b0;
        vl_raddr = owner_reg[V_AW-1:0];
        en_we    = 1'b0;
        en_waddr = used_reg[E_AW-1:0];
        en_wdata = {EMPTY_LINK, nbr_reg};
        en_re    = 1'b0;
        en_raddr = vl_head;
        q_we     = 1'b0;
        q_waddr  = wp_reg[V_AW-1:0];
        q_wdata  = en_nb;
        q_re     = 1'b0;
        q_raddr  = rp_reg[V_AW-1:0];

        had_list = hv_reg[owner_reg[V_AW-1:0]];
        enq      = !disc_reg[en_nb[V_AW-1:0]];

        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_EMIT);

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    owner_next  = in_item.vertex_a;
                    nbr_next    = in_item.vertex_b;
                    second_next = 1'b0;
                    res_next    = '{status: ST_OK, last: 1'b1, vertex: '0};
                    unique case (gbfs_op_t'(in_item.opcode))
                        OP_ADD_EDGE: begin
                            if (a_bad || b_bad) begin
                                res_next.status = ST_RANGE;
                                state_next      = S_EMIT;
                            end else if (used_reg > FULL_LEVEL) begin
                                res_next.status = ST_FULL;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_ADD_RD;
                            end
                        end
                        OP_TRAVERSE: begin
                            if (a_bad) begin
                                res_next.status = ST_RANGE;
                                state_next      = S_EMIT;
                            end else begin
                                state_next = S_TRV_INIT;
                            end
                        end
                        OP_CLEAR: begin
                            hv_next    = '0;
                            used_next  = '0;
                            state_next = S_EMIT;
                        end
                        OP_NONE: begin
                            state_next = S_IDLE;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_ADD_RD: begin
                vl_re      = 1'b1;
                state_next = S_ADD_WR;
            end
            S_ADD_WR: begin
                en_we    = 1'b1;
                vl_we    = 1'b1;
                vl_wdata = {used_reg[E_AW-1:0], had_list ? vl_head : used_reg[E_AW-1:0]};
                en_re    = had_list;
                en_raddr = vl_tail;
                hv_next[owner_reg[V_AW-1:0]] = 1'b1;
                tail_next  = vl_tail;
                new_e_next = used_reg[E_AW-1:0];
                used_next  = used_reg + LINK_W'(1);
                state_next = had_list ? S_ADD_LINK : S_ADD_STEP;
            end
            S_ADD_LINK: begin
                en_we      = 1'b1;
                en_waddr   = tail_reg;
                en_wdata   = {1'b0, new_e_reg, en_nb};
                state_next = S_ADD_STEP;
            end
            S_ADD_STEP: begin
                if (second_reg) begin
                    state_next = S_EMIT;
                end else begin
                    owner_next  = nbr_reg;
                    nbr_next    = owner_reg;
                    second_next = 1'b1;
                    state_next  = S_ADD_RD;
                end
            end
            S_TRV_INIT: begin
                q_we      = 1'b1;
                q_waddr   = '0;
                q_wdata   = owner_reg;
                disc_next = '0;
                disc_next[owner_reg[V_AW-1:0]] = 1'b1;
                rp_next    = '0;
                wp_next    = QP_W'(1);
                state_next = S_TRV_POP;
            end
            S_TRV_POP: begin
                q_re       = 1'b1;
                rp_next    = rp_reg + QP_W'(1);
                state_next = S_TRV_HEAD;
            end
            S_TRV_HEAD: begin
                cur_next   = q_rdata;
                vl_re      = 1'b1;
                vl_raddr   = q_rdata[V_AW-1:0];
                state_next = S_TRV_LIST;
            end
            S_TRV_LIST: begin
                res_next = '{status: ST_OK, last: (rp_reg == wp_reg), vertex: cur_reg};
                if (hv_reg[cur_reg[V_AW-1:0]]) begin
                    en_re      = 1'b1;
                    en_raddr   = vl_head;
                    state_next = S_TRV_ENT;
                end else begin
                    state_next = S_EMIT;
                end
            end
            S_TRV_ENT: begin
                if (enq) begin
                    q_we    = 1'b1;
                    disc_next[en_nb[V_AW-1:0]] = 1'b1;
                    wp_next = wp_reg + QP_W'(1);
                end
                if (en_link == EMPTY_LINK) begin
                    res_next   = '{status: ST_OK, last: (rp_reg == wp_next), vertex: cur_reg};
                    state_next = S_EMIT;
                end else begin
                    en_re    = 1'b1;
                    en_raddr = en_link[E_AW-1:0];
                end
            end
            S_EMIT: begin
                if (res_ready) begin
                    state_next = res_reg.last ? S_IDLE : S_TRV_POP;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            second_reg <= 1'b0;
            used_reg   <= '0;
            rp_reg     <= '0;
            wp_reg     <= '0;
            hv_reg     <= '0;
            disc_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            second_reg <= second_next;
            used_reg   <= used_next;
            rp_reg     <= rp_next;
            wp_reg     <= wp_next;
            hv_reg     <= hv_next;
            disc_reg   <= disc_next;
        end
        owner_reg <= owner_next;
        nbr_reg   <= nbr_next;
        tail_reg  <= tail_next;
        new_e_reg <= new_e_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
    end

    assign res = res_reg;

endmodule

`default_nettype wire
